[rtl/core/aeow_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Edit operation walker package
// Operation codes, fixed widths and the decode record shared by the walker.
// ----------------------------------------------------------------------------
package aeow_pkg;

	localparam int OUT_BITS      = 32;
	localparam int RUN_STEP_BITS = 16;
	localparam int OP_BITS       = 4;
	localparam int IN_DATA_BITS  = 8;
	localparam int OUT_DATA_BITS = 4 * OUT_BITS + RUN_STEP_BITS;

	localparam logic [OP_BITS-1:0] OP_MATCH        = 4'd0;
	localparam logic [OP_BITS-1:0] OP_MISMATCH     = 4'd1;
	localparam logic [OP_BITS-1:0] OP_DELETION     = 4'd2;
	localparam logic [OP_BITS-1:0] OP_INSERTION    = 4'd3;
	localparam logic [OP_BITS-1:0] OP_INTRON       = 4'd4;
	localparam logic [OP_BITS-1:0] OP_INTRON_1LEFT = 4'd5;
	localparam logic [OP_BITS-1:0] OP_INTRON_2LEFT = 4'd6;
	localparam logic [OP_BITS-1:0] OP_MISM_1GAP    = 4'd7;
	localparam logic [OP_BITS-1:0] OP_MISM_2GAP    = 4'd8;
	localparam logic [OP_BITS-1:0] OP_DEL_1GAP     = 4'd9;
	localparam logic [OP_BITS-1:0] OP_DEL_2GAP     = 4'd10;

	localparam logic [1:0] CODON_LEN       = 2'd3;
	localparam logic [1:0] CODON_LEN_LESS1 = CODON_LEN - 2'd1;
	localparam logic [1:0] CODON_LEN_LESS2 = CODON_LEN - 2'd2;

	typedef struct packed {
		logic       bad;
		logic [1:0] genomic_inc;
		logic       reference_inc;
		logic       one_left_next;
		logic       two_left_next;
	} step_ctrl_t;

endpackage
`default_nettype wire

[rtl/core/aeow_decode.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Edit operation decoder
// Checks the operation against mode and split-codon flags and gives the
// genomic and reference advances together with the next flag values.
// ----------------------------------------------------------------------------
module aeow_decode (
	input  wire logic [aeow_pkg::OP_BITS-1:0] op_type,
	input  wire logic                         protein_mode,
	input  wire logic                         one_left,
	input  wire logic                         two_left,
	output aeow_pkg::step_ctrl_t              ctrl
);
	import aeow_pkg::*;

	always_comb begin
		ctrl.bad           = 1'b0;
		ctrl.genomic_inc   = 2'd0;
		ctrl.reference_inc = 1'b0;
		ctrl.one_left_next = one_left;
		ctrl.two_left_next = two_left;
		case (op_type)
			OP_MATCH, OP_MISMATCH: begin
				if (!protein_mode) begin
					ctrl.genomic_inc   = 2'd1;
					ctrl.reference_inc = 1'b1;
				end else if (one_left) begin
					ctrl.one_left_next = 1'b0;
					ctrl.genomic_inc   = CODON_LEN_LESS1;
					ctrl.reference_inc = 1'b1;
				end else if (two_left) begin
					ctrl.two_left_next = 1'b0;
					ctrl.genomic_inc   = CODON_LEN_LESS2;
				end else begin
					ctrl.genomic_inc   = CODON_LEN;
					ctrl.reference_inc = 1'b1;
				end
			end
			OP_DELETION: begin
				ctrl.genomic_inc = protein_mode ? CODON_LEN : 2'd1;
			end
			OP_INSERTION: begin
				ctrl.reference_inc = 1'b1;
			end
			OP_INTRON: begin
				ctrl.bad         = one_left || two_left;
				ctrl.genomic_inc = 2'd1;
			end
			OP_INTRON_1LEFT: begin
				ctrl.bad = !protein_mode || two_left;
				if (!one_left) begin
					ctrl.one_left_next = 1'b1;
					ctrl.genomic_inc   = 2'd2;
				end else begin
					ctrl.genomic_inc = 2'd1;
				end
			end
			OP_INTRON_2LEFT: begin
				ctrl.bad = !protein_mode || one_left;
				if (!two_left) begin
					ctrl.two_left_next = 1'b1;
					ctrl.genomic_inc   = 2'd3;
					ctrl.reference_inc = 1'b1;
				end else begin
					ctrl.genomic_inc = 2'd1;
				end
			end
			OP_MISM_1GAP: begin
				ctrl.bad = !protein_mode;
				if (one_left) begin
					ctrl.one_left_next = 1'b0;
					ctrl.genomic_inc   = 2'd1;
					ctrl.reference_inc = 1'b1;
				end else if (two_left) begin
					ctrl.two_left_next = 1'b0;
				end else begin
					ctrl.genomic_inc   = 2'd2;
					ctrl.reference_inc = 1'b1;
				end
			end
			OP_MISM_2GAP: begin
				ctrl.bad           = !protein_mode;
				ctrl.reference_inc = 1'b1;
				if (one_left) begin
					ctrl.one_left_next = 1'b0;
				end else begin
					ctrl.genomic_inc = 2'd1;
				end
			end
			OP_DEL_1GAP: begin
				ctrl.bad = !protein_mode;
				if (one_left) begin
					ctrl.one_left_next = 1'b0;
					ctrl.genomic_inc   = 2'd1;
				end else begin
					ctrl.genomic_inc = 2'd2;
				end
			end
			OP_DEL_2GAP: begin
				ctrl.bad         = !protein_mode;
				ctrl.genomic_inc = one_left ? 2'd0 : 2'd1;
			end
			default: begin
				ctrl.bad = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/core/aeow_counters.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Edit operation walker counters
// Holds the saturating totals and split-codon flags, and presents the totals
// as they stand after the request being committed.
// ----------------------------------------------------------------------------
module aeow_counters #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               commit,
	input  wire logic                               run_last,
	input  wire aeow_pkg::step_ctrl_t               ctrl,
	output logic                                    one_left,
	output logic                                    two_left,
	output logic [3:0][aeow_pkg::OUT_BITS-1:0]      totals,
	output logic [aeow_pkg::RUN_STEP_BITS-1:0]      steps_in_run
);
	import aeow_pkg::*;

	localparam int STEP_IDX = 0;
	localparam int GEN_IDX  = 1;
	localparam int REF_IDX  = 2;
	localparam int RUN_IDX  = 3;

	logic [3:0][COUNT_BITS-1:0]  cnt_q;
	logic [3:0][COUNT_BITS-1:0]  cnt_d;
	logic [RUN_STEP_BITS-1:0]    run_step_q;
	logic [RUN_STEP_BITS-1:0]    run_step_d;
	logic                        one_left_q;
	logic                        two_left_q;
	logic                        legal;

	function automatic logic [COUNT_BITS-1:0] sat_add(
		input logic [COUNT_BITS-1:0] c,
		input logic [1:0]            d
	);
		logic [COUNT_BITS:0] s;
		s = {1'b0, c} + {{(COUNT_BITS-1){1'b0}}, d};
		return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
	endfunction

	assign legal = commit && !ctrl.bad;

	always_comb begin
		cnt_d      = cnt_q;
		run_step_d = run_step_q;
		if (legal) begin
			cnt_d[STEP_IDX] = sat_add(cnt_q[STEP_IDX], 2'd1);
			cnt_d[GEN_IDX]  = sat_add(cnt_q[GEN_IDX], ctrl.genomic_inc);
			cnt_d[REF_IDX]  = sat_add(cnt_q[REF_IDX], {1'b0, ctrl.reference_inc});
			if (run_last) begin
				cnt_d[RUN_IDX] = sat_add(cnt_q[RUN_IDX], 2'd1);
				run_step_d     = '0;
			end else if (run_step_q != {RUN_STEP_BITS{1'b1}}) begin
				run_step_d = run_step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			run_step_q <= '0;
			one_left_q <= 1'b0;
			two_left_q <= 1'b0;
		end else begin
			cnt_q      <= cnt_d;
			run_step_q <= run_step_d;
			if (legal) begin
				one_left_q <= ctrl.one_left_next;
				two_left_q <= ctrl.two_left_next;
			end
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_show
		if (COUNT_BITS > OUT_BITS) begin : g_clip
			assign totals[i] = (|cnt_d[i][COUNT_BITS-1:OUT_BITS]) ?
				{OUT_BITS{1'b1}} : cnt_d[i][OUT_BITS-1:0];
		end else begin : g_ext
			assign totals[i] = OUT_BITS'(cnt_d[i]);
		end
	end

	assign steps_in_run = run_step_d;
	assign one_left     = one_left_q;
	assign two_left     = two_left_q;

`ifndef SYNTHESIS
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(one_left_q && two_left_q))
		else $error("Both split-codon flags are set.");

	a_legal_counts: assert property (@(posedge clk) disable iff (!arst_n)
		legal |=> cnt_q[STEP_IDX] != '0)
		else $error("Step total is zero after a legal request.");

	a_illegal_holds: assert property (@(posedge clk) disable iff (!arst_n)
		commit && ctrl.bad |=> $stable(cnt_q) && $stable(run_step_q)
			&& $stable(one_left_q) && $stable(two_left_q))
		else $error("State changed on an illegal request.");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(cnt_q) && $stable(run_step_q))
		else $error("State changed without a request.");
`endif

endmodule
`default_nettype wire

[rtl/core/alignment_edit_op_walker_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Alignment edit operation walker
// Walks edit operations one unit step at a time and reports running totals.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_*       in         one unit of an edit operation run
// m_*       out        totals after that unit, and the illegal flag
// cfg_*     in         protein mode register
//
// A request is registered on entry, evaluated against the state while it
// waits in the entry register, and its result registered on the way out.
// One request per cycle is sustained while the output is not stalled; the
// state update is decode and small saturating adds. A stalled output holds
// the result and backs up through the entry register. Reset clears all
// totals, flags and the mode register.
// ----------------------------------------------------------------------------
module alignment_edit_op_walker_core #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic                                cfg_wdata,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// [3:0] op_type, [7:4] zero
	input  wire logic [aeow_pkg::IN_DATA_BITS-1:0]   s_tdata,
	input  wire logic                                s_tlast,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// [31:0] step_total, [63:32] genomic_offset, [95:64] reference_offset,
	// [127:96] runs_done, [143:128] steps_in_run
	output logic [aeow_pkg::OUT_DATA_BITS-1:0]       m_tdata,
	// [0] illegal_op
	output logic                                     m_tuser
);
	import aeow_pkg::*;

	logic                         protein_mode_q;
	logic                         valid_s1;
	logic [OP_BITS-1:0]           op_s1;
	logic                         last_s1;
	logic                         advance;
	logic                         one_left;
	logic                         two_left;
	step_ctrl_t                   ctrl;
	logic [3:0][OUT_BITS-1:0]     totals;
	logic [RUN_STEP_BITS-1:0]     steps_in_run;
	logic                         out_valid_q;
	logic [OUT_DATA_BITS-1:0]     out_data_q;
	logic                         out_user_q;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protein_mode_q <= 1'b0;
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				protein_mode_q <= cfg_wdata;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tdata[OP_BITS-1:0];
			last_s1 <= s_tlast;
		end
		if (advance) begin
			out_data_q <= {steps_in_run, totals[3], totals[2], totals[1], totals[0]};
			out_user_q <= ctrl.bad;
		end
	end

	aeow_decode u_decode (
		.op_type      (op_s1),
		.protein_mode (protein_mode_q),
		.one_left     (one_left),
		.two_left     (two_left),
		.ctrl         (ctrl)
	);

	aeow_counters #(
		.COUNT_BITS (COUNT_BITS)
	) u_counters (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (advance),
		.run_last     (last_s1),
		.ctrl         (ctrl),
		.one_left     (one_left),
		.two_left     (two_left),
		.totals       (totals),
		.steps_in_run (steps_in_run)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule
`default_nettype wire

[tb/walker_totals_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Edit operation walker result checker
// Watches the request, result and mode channels of the walker. For every
// accepted request it advances its own copy of the walk state and queues the
// totals that the block should report; every accepted result is compared with
// the oldest queued totals. The failure count and the number of outstanding
// results are handed to the testbench top.
// ----------------------------------------------------------------------------
module walker_totals_checker #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_wdata,
	input  wire logic                              s_tvalid,
	input  wire logic                              s_tready,
	input  wire logic [aeow_pkg::IN_DATA_BITS-1:0] s_tdata,
	input  wire logic                              s_tlast,
	input  wire logic                              m_tvalid,
	input  wire logic                              m_tready,
	input  wire logic [aeow_pkg::OUT_DATA_BITS-1:0] m_tdata,
	input  wire logic                              m_tuser,
	output int                                     fail_count,
	output int                                     pending
);

	import aeow_pkg::*;

	typedef struct packed {
		logic [OUT_BITS-1:0]      steps;
		logic [OUT_BITS-1:0]      genomic;
		logic [OUT_BITS-1:0]      reference;
		logic [OUT_BITS-1:0]      runs;
		logic [RUN_STEP_BITS-1:0] run_steps;
		logic                     illegal;
	} walk_totals_t;

	localparam logic [63:0] COUNT_MAX =
		(COUNT_BITS >= 64) ? '1 : ((64'd1 << COUNT_BITS) - 64'd1);

	logic [63:0]              step_cnt;
	logic [63:0]              genomic_cnt;
	logic [63:0]              reference_cnt;
	logic [63:0]              run_cnt;
	logic [RUN_STEP_BITS-1:0] run_step_cnt;
	logic                     one_left;
	logic                     two_left;
	logic                     protein;
	walk_totals_t             expected_totals[$];
	int                       mismatches;

	function automatic logic [63:0] sat_inc(logic [63:0] c, logic [63:0] d);
		if (c >= COUNT_MAX || COUNT_MAX - c < d)
			return COUNT_MAX;
		return c + d;
	endfunction

	function automatic logic [OUT_BITS-1:0] clip(logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[OUT_BITS-1:0];
	endfunction

	// Applies one unit step to the walk state and returns the totals after it.
	function automatic walk_totals_t advance_walk(logic [OP_BITS-1:0] op, logic last);
		logic         bad;
		logic [1:0]   g;
		logic         r;
		walk_totals_t res;
		g = 2'd0;
		r = 1'b0;
		case (op)
			OP_MATCH, OP_MISMATCH, OP_DELETION, OP_INSERTION: bad = 1'b0;
			OP_INTRON:       bad = one_left | two_left;
			OP_INTRON_1LEFT: bad = !protein | two_left;
			OP_INTRON_2LEFT: bad = !protein | one_left;
			OP_MISM_1GAP, OP_MISM_2GAP, OP_DEL_1GAP, OP_DEL_2GAP: bad = !protein;
			default:         bad = 1'b1;
		endcase
		if (!bad) begin
			case (op)
				OP_MATCH, OP_MISMATCH: begin
					if (!protein) begin
						g = 2'd1;
						r = 1'b1;
					end else if (one_left) begin
						one_left = 1'b0;
						g = CODON_LEN_LESS1;
						r = 1'b1;
					end else if (two_left) begin
						two_left = 1'b0;
						g = CODON_LEN_LESS2;
					end else begin
						g = CODON_LEN;
						r = 1'b1;
					end
				end
				OP_DELETION: g = protein ? CODON_LEN : 2'd1;
				OP_INSERTION: r = 1'b1;
				OP_INTRON: g = 2'd1;
				OP_INTRON_1LEFT: begin
					if (one_left) begin
						g = 2'd1;
					end else begin
						one_left = 1'b1;
						g = 2'd2;
					end
				end
				OP_INTRON_2LEFT: begin
					if (two_left) begin
						g = 2'd1;
					end else begin
						two_left = 1'b1;
						g = 2'd3;
						r = 1'b1;
					end
				end
				OP_MISM_1GAP: begin
					if (one_left) begin
						one_left = 1'b0;
						g = 2'd1;
						r = 1'b1;
					end else if (two_left) begin
						two_left = 1'b0;
					end else begin
						g = 2'd2;
						r = 1'b1;
					end
				end
				OP_MISM_2GAP: begin
					if (one_left) begin
						one_left = 1'b0;
						r = 1'b1;
					end else begin
						g = 2'd1;
						r = 1'b1;
					end
				end
				OP_DEL_1GAP: begin
					if (one_left) begin
						one_left = 1'b0;
						g = 2'd1;
					end else begin
						g = 2'd2;
					end
				end
				OP_DEL_2GAP: begin
					if (!one_left)
						g = 2'd1;
				end
				default: ;
			endcase
			step_cnt = sat_inc(step_cnt, 64'd1);
			genomic_cnt = sat_inc(genomic_cnt, {62'd0, g});
			reference_cnt = sat_inc(reference_cnt, {63'd0, r});
			if (last) begin
				run_cnt = sat_inc(run_cnt, 64'd1);
				run_step_cnt = '0;
			end else if (run_step_cnt != '1) begin
				run_step_cnt = run_step_cnt + 1'b1;
			end
		end
		res.steps = clip(step_cnt);
		res.genomic = clip(genomic_cnt);
		res.reference = clip(reference_cnt);
		res.runs = clip(run_cnt);
		res.run_steps = run_step_cnt;
		res.illegal = bad;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		walk_totals_t got;
		walk_totals_t want;
		if (!arst_n) begin
			step_cnt = '0;
			genomic_cnt = '0;
			reference_cnt = '0;
			run_cnt = '0;
			run_step_cnt = '0;
			one_left = 1'b0;
			two_left = 1'b0;
			protein = 1'b0;
			expected_totals.delete();
			mismatches = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
					m_tdata[143:128], m_tuser};
				if (expected_totals.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with no request outstanding: steps=%0d genomic=%0d ref=%0d runs=%0d in_run=%0d illegal=%0b",
							$realtime, got.steps, got.genomic, got.reference, got.runs,
							got.run_steps, got.illegal);
					mismatches++;
				end else begin
					want = expected_totals.pop_front();
					if (got !== want) begin
						if (mismatches < 10) begin
							$display("%0t: wrong result: expected steps=%0d genomic=%0d ref=%0d runs=%0d in_run=%0d illegal=%0b",
								$realtime, want.steps, want.genomic, want.reference, want.runs,
								want.run_steps, want.illegal);
							$display("%0t:                 got steps=%0d genomic=%0d ref=%0d runs=%0d in_run=%0d illegal=%0b",
								$realtime, got.steps, got.genomic, got.reference, got.runs,
								got.run_steps, got.illegal);
						end
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_totals.push_back(advance_walk(s_tdata[OP_BITS-1:0], s_tlast));
			if (cfg_we)
				protein = cfg_wdata;
		end
		fail_count <= mismatches;
		pending <= expected_totals.size();
	end

endmodule

[tb/alignment_edit_op_walker_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Edit operation walker testbench
// Drives unit steps of edit operation runs into the walker, in nucleotide and
// protein mode, with random gaps on both channels, a long output stall and
// malformed requests mixed in. Checking is done by the checker instance; this
// module gives the verdict.
// ----------------------------------------------------------------------------
module alignment_edit_op_walker_core_tb;

	import aeow_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 60;
	localparam logic [OP_BITS-1:0] OP_UNDEF_LO = 4'd11;
	localparam logic [OP_BITS-1:0] OP_UNDEF_HI = 4'd15;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic                     cfg_wdata = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic [IN_DATA_BITS-1:0]  s_tdata = '0;
	logic                     s_tlast = 1'b0;
	logic                     m_tready = 1'b0;
	wire                      s_tready;
	wire                      m_tvalid;
	wire [OUT_DATA_BITS-1:0]  m_tdata;
	wire                      m_tuser;
	int                       fail_count;
	int                       pending;
	int                       items_sent = 0;
	bit                       steady = 1'b0;
	bit                       rx_hold = 1'b0;
	bit                       protein_now = 1'b0;

	always #5 clk = ~clk;

	alignment_edit_op_walker_core #(
		.COUNT_BITS(32)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	walker_totals_checker #(
		.COUNT_BITS(32)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.fail_count(fail_count),
		.pending   (pending)
	);

	task automatic send_item(input logic [OP_BITS-1:0] op, input logic last);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 6);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_BITS-OP_BITS){1'b0}}, op};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_mode(input logic mode);
		drain();
		repeat (3) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
		protein_now = mode;
	endtask

	// One run of a single operation type, a split-codon intron followed by a
	// codon-type run, or a single request with a random, possibly malformed, operation code.
	task automatic send_run();
		int                 kind;
		int                 len;
		int                 pick;
		logic [OP_BITS-1:0] op;
		kind = $urandom_range(0, 99);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
		if (kind < 10) begin
			send_item(OP_BITS'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
		end else if (kind < 35 && protein_now) begin
			op = $urandom_range(0, 1) ? OP_INTRON_1LEFT : OP_INTRON_2LEFT;
			pick = $urandom_range(1, 2);
			for (int i = 1; i <= pick; i++)
				send_item(op, i == pick);
			case ($urandom_range(0, 5))
				0: op = OP_MATCH;
				1: op = OP_MISMATCH;
				2: op = OP_MISM_1GAP;
				3: op = OP_MISM_2GAP;
				4: op = OP_DEL_1GAP;
				default: op = OP_DEL_2GAP;
			endcase
			pick = $urandom_range(1, 3);
			for (int i = 1; i <= pick; i++)
				send_item(op, i == pick);
		end else begin
			pick = $urandom_range(0, 9);
			case (pick)
				0, 1, 2: op = OP_MATCH;
				3: op = OP_MISMATCH;
				4: op = OP_DELETION;
				5: op = OP_INSERTION;
				6: op = OP_INTRON;
				default: op = protein_now ?
					OP_BITS'($urandom_range(OP_MISM_1GAP, OP_DEL_2GAP)) : OP_MATCH;
			endcase
			for (int i = 1; i <= len; i++)
				send_item(op, i == len);
		end
	endtask

	task automatic random_phase(input int count);
		int start;
		start = items_sent;
		while (items_sent - start < count)
			send_run();
	endtask

	initial begin : result_sink
		int gap;
		forever begin
			if (rx_hold) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold = 1'b0;
			end else begin
				gap = steady ? 0 : $urandom_range(0, 6);
				repeat (gap) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
				@(negedge clk);
				m_tready <= 1'b1;
				do @(posedge clk); while (!m_tvalid);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_mode(1'b0);
		send_item(OP_MATCH, 1'b0);
		send_item(OP_MISMATCH, 1'b1);
		send_item(OP_DELETION, 1'b0);
		send_item(OP_INSERTION, 1'b1);
		send_item(OP_INTRON, 1'b1);
		send_item(OP_INTRON_1LEFT, 1'b1);
		send_item(OP_MISM_2GAP, 1'b0);
		send_item(OP_UNDEF_LO, 1'b1);
		send_item(OP_UNDEF_HI, 1'b1);

		write_mode(1'b1);
		send_item(OP_INTRON_2LEFT, 1'b1);
		send_item(OP_INTRON, 1'b1);
		send_item(OP_INTRON_1LEFT, 1'b1);
		send_item(OP_INTRON_2LEFT, 1'b1);
		send_item(OP_MISM_1GAP, 1'b1);
		send_item(OP_INTRON_1LEFT, 1'b0);
		send_item(OP_INTRON_2LEFT, 1'b1);
		send_item(OP_MATCH, 1'b1);
		send_item(OP_INTRON_1LEFT, 1'b1);
		send_item(OP_MISM_2GAP, 1'b1);
		send_item(OP_INTRON_1LEFT, 1'b1);
		send_item(OP_DEL_2GAP, 1'b0);
		send_item(OP_DEL_1GAP, 1'b1);
		send_item(OP_INTRON_2LEFT, 1'b1);
		send_item(OP_MISMATCH, 1'b1);
		send_item(OP_INTRON_1LEFT, 1'b1);

		// The split-codon flag survives the change to nucleotide mode.
		write_mode(1'b0);
		send_item(OP_MATCH, 1'b1);
		send_item(OP_INTRON, 1'b1);

		write_mode(1'b1);
		random_phase(250);
		steady = 1'b1;
		random_phase(120);
		steady = 1'b0;
		random_phase(130);

		write_mode(1'b0);
		random_phase(300);

		write_mode(1'b1);
		random_phase(200);
		// The output stalls while requests keep coming, so the block backs up.
		rx_hold = 1'b1;
		steady = 1'b1;
		random_phase(30);
		steady = 1'b0;
		drain();
		random_phase(300);

		write_mode(1'b1);
		random_phase(200);

		drain();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
